@@ design/lfpes_pkg.sv @@
// shared types and constants of the line follower pid controller
package lfpes_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] REG_PROP   = 3'd0;
	localparam logic [2:0] REG_INTEG  = 3'd1;
	localparam logic [2:0] REG_DERIV  = 3'd2;
	localparam logic [2:0] REG_HALF   = 3'd3;
	localparam logic [2:0] REG_BOOST  = 3'd4;
	localparam logic [2:0] REG_BLACK  = 3'd5;
	localparam logic [2:0] REG_CENTER = 3'd6;
	localparam logic [2:0] REG_TRIG   = 3'd7;

	localparam logic [2:0] BASE_NORMAL     = 3'd6;
	localparam logic [2:0] BASE_RAMP       = 3'd4;
	localparam logic [2:0] BASE_RESET      = 3'd5;
	localparam logic [1:0] RAMP_STEP_TICKS = 2'd3;
	localparam int         DUTY_LIMIT      = 100;
	localparam int         STEER_LIMIT     = 127;

	typedef struct packed {
		logic [15:0] prop_gain_q8;
		logic [15:0] integ_gain_q8;
		logic [15:0] deriv_gain_per_dt_q8;
		logic [15:0] half_tick_q16;
		logic [15:0] boost_gain_q8;
		logic [6:0]  black_level;
		logic [6:0]  center_level;
		logic [30:0] trigger_count;
	} cfg_t;

	// one classified tick on its way to the arithmetic
	typedef struct packed {
		logic signed [7:0] err;
		logic signed [7:0] prev;
		logic              boost_on;
		logic [2:0]        base_duty;
		logic              on_right;
		logic [6:0]        target;
	} tick_t;

	typedef struct packed {
		logic on_right;
		logic triggered;
	} fr_stat_t;

	typedef struct packed {
		logic idle;
		logic at_out;
	} bk_stat_t;

endpackage

@@ design/lfpes_front.sv @@
// front end: target ramp sequencing, error and trigger handling per tick
module lfpes_front import lfpes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              accept,
	input  logic [6:0]        reflection,
	input  logic [31:0]       encoder_count,
	output tick_t             tick,
	output fr_stat_t          stat
);

	logic [6:0]        target_q, n_target;
	logic signed [7:0] prev_q;
	logic [1:0]        tick_q, n_tick, tick_inc;
	logic              edge_q, n_edge;
	logic              past_q, n_past;
	logic              ramp_q, n_ramp;
	logic              trig_q, n_trig;
	logic              boost_q, n_boost;
	logic [2:0]        base_q, n_base;
	logic signed [7:0] err;
	logic              fire;

	always_comb begin
		n_target = target_q;
		n_tick   = tick_q;
		n_edge   = edge_q;
		n_past   = past_q;
		n_ramp   = ramp_q;
		n_trig   = trig_q;
		n_boost  = boost_q;
		n_base   = base_q;
		tick_inc = tick_q + 2'd1;
		fire     = (tick_inc == RAMP_STEP_TICKS);
		if (!ramp_q) begin
			n_target = cfg.center_level;
			n_boost  = 1'b0;
			n_base   = BASE_NORMAL;
		end else if (!past_q && target_q > cfg.black_level) begin
			n_base = BASE_RAMP;
			n_tick = fire ? 2'd0 : tick_inc;
			if (fire) begin
				n_boost  = 1'b1;
				n_target = target_q - 7'd1;
			end
		end else if (!past_q && target_q == cfg.black_level) begin
			n_base = BASE_RAMP;
			n_tick = fire ? 2'd0 : tick_inc;
			if (fire) begin
				n_boost = 1'b1;
				n_edge  = 1'b1;
				n_past  = 1'b1;
			end
		end else if (past_q && target_q < cfg.center_level) begin
			n_base = BASE_RAMP;
			n_tick = fire ? 2'd0 : tick_inc;
			if (fire) begin
				n_boost  = 1'b1;
				n_target = target_q + 7'd1;
			end
			if (n_target == cfg.center_level) begin
				n_past = 1'b0;
				n_ramp = 1'b0;
			end
		end
		// ramp starts once, checked after this tick's result
		if ($signed(encoder_count) >= $signed({1'b0, cfg.trigger_count}) && !trig_q) begin
			n_ramp = 1'b1;
			n_trig = 1'b1;
		end
	end

	assign err = $signed({1'b0, n_target}) - $signed({1'b0, reflection});

	assign tick.err        = err;
	assign tick.prev       = prev_q;
	assign tick.boost_on   = n_boost;
	assign tick.base_duty  = n_base;
	assign tick.on_right   = n_edge;
	assign tick.target     = n_target;

	assign stat.on_right   = edge_q;
	assign stat.triggered  = trig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			prev_q   <= '0;
			tick_q   <= '0;
			edge_q   <= 1'b0;
			past_q   <= 1'b0;
			ramp_q   <= 1'b0;
			trig_q   <= 1'b0;
			boost_q  <= 1'b0;
			base_q   <= BASE_RESET;
		end else if (accept) begin
			target_q <= n_target;
			prev_q   <= err;
			tick_q   <= n_tick;
			edge_q   <= n_edge;
			past_q   <= n_past;
			ramp_q   <= n_ramp;
			trig_q   <= n_trig;
			boost_q  <= n_boost;
			base_q   <= n_base;
		end
	end

endmodule

@@ design/lfpes_queue.sv @@
// short queue between the front end and the arithmetic back end
module lfpes_queue import lfpes_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  tick_t push_data,
	output logic  not_full,
	input  logic  pop,
	output logic  not_empty,
	output tick_t pop_data
);

	tick_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign not_full  = (cnt_q != QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/lfpes_back.sv @@
// back end: integral, steering and duty saturation as a multi-cycle sequence
module lfpes_back import lfpes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  tick_t             q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] left_duty,
	output logic signed [7:0] right_duty,
	output logic [6:0]        target_level,
	output bk_stat_t          stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_INT  = 3'd3;
	localparam logic [2:0] ST_KI   = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;
	localparam logic [2:0] ST_RND  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]         state_q;
	tick_t              ent_q;
	logic signed [31:0] integ_q;
	logic signed [25:0] pi_q, pp_q, dp_q;
	logic signed [48:0] acc_q, kip_q;
	logic signed [26:0] pd_q;
	logic signed [49:0] total_q;
	logic signed [7:0]  steer_q;
	logic               out_valid_q;
	logic signed [7:0]  left_q, right_q;
	logic [6:0]         target_q;

	logic signed [8:0]  esum, ediff;
	logic signed [17:0] gain;
	logic signed [48:0] acc_rnd;
	logic signed [32:0] acc_sh;
	logic signed [31:0] integ_sat;
	logic signed [49:0] tot_rnd;
	logic signed [41:0] steer_full;
	logic signed [7:0]  steer_sat;
	logic signed [8:0]  steer_dir;
	logic signed [9:0]  left_raw, right_raw;
	logic signed [7:0]  left_sat, right_sat;
	logic               load_out;

	assign esum  = 9'(ent_q.err) + 9'(ent_q.prev);
	assign ediff = 9'(ent_q.err) - 9'(ent_q.prev);
	assign gain  = $signed({2'b00, cfg.prop_gain_q8})
		+ (ent_q.boost_on ? $signed({2'b00, cfg.boost_gain_q8}) : 18'sd0);

	// division by 2^16 truncated toward zero, then held to the 32-bit range
	assign acc_rnd = acc_q + (acc_q[48] ? 49'sd65535 : 49'sd0);
	assign acc_sh  = acc_rnd[48:16];
	assign integ_sat = (acc_sh[32] != acc_sh[31]) ?
		(acc_sh[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : acc_sh[31:0];

	assign tot_rnd    = total_q + (total_q[49] ? 50'sd255 : 50'sd0);
	assign steer_full = tot_rnd[49:8];
	assign steer_sat  = (steer_full > 42'(STEER_LIMIT)) ? 8'(STEER_LIMIT) :
		(steer_full < -42'(STEER_LIMIT)) ? -8'(STEER_LIMIT) : steer_full[7:0];

	assign steer_dir = ent_q.on_right ? 9'(steer_q) : -9'(steer_q);
	assign left_raw  = $signed({7'b0, ent_q.base_duty}) + 10'(steer_dir);
	assign right_raw = $signed({7'b0, ent_q.base_duty}) - 10'(steer_dir);
	assign left_sat  = (left_raw > 10'(DUTY_LIMIT)) ? 8'(DUTY_LIMIT) :
		(left_raw < -10'(DUTY_LIMIT)) ? -8'(DUTY_LIMIT) : left_raw[7:0];
	assign right_sat = (right_raw > 10'(DUTY_LIMIT)) ? 8'(DUTY_LIMIT) :
		(right_raw < -10'(DUTY_LIMIT)) ? -8'(DUTY_LIMIT) : right_raw[7:0];

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign out_valid    = out_valid_q;
	assign left_duty    = left_q;
	assign right_duty   = right_q;
	assign target_level = target_q;
	assign stat.idle    = (state_q == ST_IDLE);
	assign stat.at_out  = (state_q == ST_OUT);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					ent_q <= q_data;
				end
			end
			ST_MUL: begin
				pi_q <= esum * $signed({1'b0, cfg.half_tick_q16});
				pp_q <= gain * ent_q.err;
				dp_q <= $signed({1'b0, cfg.deriv_gain_per_dt_q8}) * ediff;
			end
			ST_ACC: begin
				acc_q <= $signed({integ_q[31], integ_q, 16'b0}) + 49'(pi_q);
				pd_q  <= 27'(pp_q) + 27'(dp_q);
			end
			ST_KI: begin
				kip_q <= $signed({1'b0, cfg.integ_gain_q8}) * integ_q;
			end
			ST_SUM: begin
				total_q <= 50'(kip_q) + 50'(pd_q);
			end
			ST_RND: begin
				steer_q <= steer_sat;
			end
			ST_OUT: begin
				if (load_out) begin
					left_q   <= left_sat;
					right_q  <= right_sat;
					target_q <= ent_q.target;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: state_q <= ST_INT;
				ST_INT: begin
					integ_q <= integ_sat;
					state_q <= ST_KI;
				end
				ST_KI:  state_q <= ST_SUM;
				ST_SUM: state_q <= ST_RND;
				ST_RND: state_q <= ST_OUT;
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/line_follow_pid_edge_switch_top.sv @@
// top level of the line follower pid controller with edge switch
//
// one input beat per control tick: reflection and the left encoder count.
// one output beat per input beat: left and right duty limits (saturated to
// +/-100) and the brightness target used for that tick, in input order.
// both channels are valid/ready; the apb port sets gains, levels and trigger
// and must only be written while no tick is in flight.
// the front end sequences the target ramp and the edge switch and computes
// the error in the accepting cycle, then drops the tick into a two-entry
// queue, so input beats are taken back to back until the queue fills.
// the back end works one tick at a time through its steps (load, products,
// integral add, saturate, integral gain product, sum, round, duty), in an
// order set by the chain of dependent multiplies through the integral; it
// takes the next tick from the queue only after the previous one has left
// the duty step.
// a stalled receiver holds the output register; the back end then waits in
// its last step, the queue fills and in_ready drops.
// reset clears the pid and ramp state, loads the register defaults and
// empties the queue and output register.
module line_follow_pid_edge_switch_top import lfpes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [6:0]        reflection,
	input  logic signed [31:0] encoder_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] left_duty,
	output logic signed [7:0] right_duty,
	output logic [6:0]        target_level
);

	cfg_t     cfg_q;
	tick_t    fr_tick, q_data;
	fr_stat_t fr_stat;
	bk_stat_t bk_stat;
	logic     in_accept, q_valid, q_pop, q_not_full;
	logic     cfg_wr;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign in_ready  = q_not_full;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain_q8         <= 16'd256;
			cfg_q.integ_gain_q8        <= 16'd0;
			cfg_q.deriv_gain_per_dt_q8 <= 16'd0;
			cfg_q.half_tick_q16        <= 16'd131;
			cfg_q.boost_gain_q8        <= 16'd44;
			cfg_q.black_level          <= 7'd0;
			cfg_q.center_level         <= 7'd50;
			cfg_q.trigger_count        <= 31'd720;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_PROP:   cfg_q.prop_gain_q8         <= pwdata[15:0];
				REG_INTEG:  cfg_q.integ_gain_q8        <= pwdata[15:0];
				REG_DERIV:  cfg_q.deriv_gain_per_dt_q8 <= pwdata[15:0];
				REG_HALF:   cfg_q.half_tick_q16        <= pwdata[15:0];
				REG_BOOST:  cfg_q.boost_gain_q8        <= pwdata[15:0];
				REG_BLACK:  cfg_q.black_level          <= pwdata[6:0];
				REG_CENTER: cfg_q.center_level         <= pwdata[6:0];
				REG_TRIG:   cfg_q.trigger_count        <= pwdata[30:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_PROP:   prdata = {16'b0, cfg_q.prop_gain_q8};
			REG_INTEG:  prdata = {16'b0, cfg_q.integ_gain_q8};
			REG_DERIV:  prdata = {16'b0, cfg_q.deriv_gain_per_dt_q8};
			REG_HALF:   prdata = {16'b0, cfg_q.half_tick_q16};
			REG_BOOST:  prdata = {16'b0, cfg_q.boost_gain_q8};
			REG_BLACK:  prdata = {25'b0, cfg_q.black_level};
			REG_CENTER: prdata = {25'b0, cfg_q.center_level};
			REG_TRIG:   prdata = {1'b0, cfg_q.trigger_count};
			default:    prdata = '0;
		endcase
	end

	lfpes_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.accept        (in_accept),
		.reflection    (reflection),
		.encoder_count (encoder_count),
		.tick          (fr_tick),
		.stat          (fr_stat)
	);

	lfpes_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (fr_tick),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	lfpes_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_duty    (left_duty),
		.right_duty   (right_duty),
		.target_level (target_level),
		.stat         (bk_stat)
	);

	// duties always lie within the saturation limits
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_duty <= 8'sd100 && left_duty >= -8'sd100 &&
			right_duty <= 8'sd100 && right_duty >= -8'sd100))
		else $error("duty outside saturation limits");

	// a tick taken from the queue reaches the duty step after the steps from products through round
	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> ##7 bk_stat.at_out)
		else $error("back end sequence length wrong");

	// leaving the duty step always presents a beat
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_stat.at_out && !(out_valid && !out_ready)) |=> (bk_stat.idle && out_valid))
		else $error("duty step finished without output beat");

	// the trigger and the switch to the right edge are one-way
	a_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_stat.triggered || fr_stat.on_right) |=>
			(fr_stat.triggered && (fr_stat.on_right || !$past(fr_stat.on_right))))
		else $error("trigger or edge state fell back");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the line follower pid controller with edge switch
`timescale 1ns / 100ps

module testbench;
	import lfpes_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 24;
	localparam int          RX_HOLD       = 100;
	localparam int          PHASE_TICKS   = 25;
	localparam int          PHASES        = 6;
	localparam longint      INTEG_MAX     = 64'sh0000_0000_7fff_ffff;
	localparam longint      INTEG_MIN     = -INTEG_MAX - 1;

	typedef struct packed {
		logic signed [7:0] left;
		logic signed [7:0] right;
		logic [6:0]        level;
	} duty_t;

	typedef struct packed {
		logic [6:0]         refl;
		logic signed [31:0] enc;
		logic               typed;
		duty_t              want;
	} probe_t;

	// register defaults, encoder always below the trigger
	localparam probe_t DIR_TABLE [12] = '{
		'{7'd50,  32'sd0,            1'b1, '{8'sd6,   8'sd6,   7'd50}},
		'{7'd0,   32'sd0,            1'b1, '{-8'sd44, 8'sd56,  7'd50}},
		'{7'd127, 32'sd0,            1'b1, '{8'sd83,  -8'sd71, 7'd50}},
		'{7'd100, -32'sd1,           1'b1, '{8'sd56,  -8'sd44, 7'd50}},
		'{7'h55,  32'sh8000_0000,    1'b0, '0},
		'{7'h2a,  32'sd719,          1'b0, '0},
		'{7'd50,  32'sd341,          1'b0, '0},
		'{7'd0,   32'sd700,          1'b0, '0},
		'{7'd127, 32'sd1,            1'b0, '0},
		'{7'd25,  32'sd719,          1'b0, '0},
		'{7'd75,  -32'sd720,         1'b0, '0},
		'{7'd50,  32'sd718,          1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [4:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [6:0]        reflection;
	logic signed [31:0] encoder_count;
	logic              out_valid;
	logic              out_ready;
	logic signed [7:0] left_duty;
	logic signed [7:0] right_duty;
	logic [6:0]        target_level;

	line_follow_pid_edge_switch_top u_dut (.*);

	// register copy and controller state as the block should hold them
	cfg_t               regs;
	logic [6:0]         trk_target;
	logic signed [7:0]  last_err;
	logic signed [31:0] integ_acc;
	logic [1:0]         ramp_ticks;
	logic               on_right, rising, ramping, latched, boosted;
	logic [2:0]         base_lvl;

	duty_t due_duties [$];
	int    n_fail = 0;
	int    tx_gap_max = 18;
	int    rx_gap_max = 18;
	bit    rx_hold_due = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [7:0] duty_clip(input longint v);
		if (v > DUTY_LIMIT)
			v = DUTY_LIMIT;
		else if (v < -DUTY_LIMIT)
			v = -DUTY_LIMIT;
		return v[7:0];
	endfunction

	// one tick of the ramp divider, true when a ramp step fires
	function automatic logic ramp_divider();
		base_lvl = BASE_RAMP;
		ramp_ticks = ramp_ticks + 2'd1;
		if (ramp_ticks == RAMP_STEP_TICKS) begin
			ramp_ticks = '0;
			boosted = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic duty_t follow_tick(input logic [6:0] refl, input logic signed [31:0] enc);
		logic [6:0] now;
		int         err, prev;
		longint     acc, gain, steer;
		duty_t      res;
		now = trk_target;
		if (!ramping) begin
			trk_target = regs.center_level;
			boosted = 1'b0;
			base_lvl = BASE_NORMAL;
		end else if (!rising && now > regs.black_level) begin
			if (ramp_divider())
				trk_target = now - 7'd1;
		end else if (!rising && now == regs.black_level) begin
			if (ramp_divider()) begin
				on_right = 1'b1;
				rising = 1'b1;
			end
		end else if (rising && now < regs.center_level) begin
			if (ramp_divider())
				trk_target = now + 7'd1;
			if (trk_target == regs.center_level) begin
				rising = 1'b0;
				ramping = 1'b0;
			end
		end
		// anything else is a stalled ramp: nothing moves

		prev = last_err;
		err = int'(trk_target) - int'(refl);

		// trapezoidal integral, truncated toward zero then saturated
		acc = longint'(integ_acc) * 65536 + longint'(err + prev) * longint'(regs.half_tick_q16);
		acc = acc / 65536;
		if (acc > INTEG_MAX)
			acc = INTEG_MAX;
		else if (acc < INTEG_MIN)
			acc = INTEG_MIN;
		integ_acc = acc[31:0];

		gain = longint'(regs.prop_gain_q8) + (boosted ? longint'(regs.boost_gain_q8) : 64'sd0);
		acc = gain * err + longint'(regs.integ_gain_q8) * integ_acc
			+ longint'(regs.deriv_gain_per_dt_q8) * (err - prev);
		steer = acc / 256;
		if (!on_right)
			steer = -steer;

		res.left = duty_clip(longint'(base_lvl) + steer);
		res.right = duty_clip(longint'(base_lvl) - steer);
		res.level = trk_target;
		last_err = err[7:0];

		if (longint'(enc) >= longint'(regs.trigger_count) && !latched) begin
			ramping = 1'b1;
			latched = 1'b1;
		end
		return res;
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.prop_gain_q8 = 16'($urandom_range(0, 1023));
		c.integ_gain_q8 = 16'($urandom_range(0, 255));
		c.deriv_gain_per_dt_q8 = 16'($urandom_range(0, 1023));
		c.half_tick_q16 = 16'($urandom());
		c.boost_gain_q8 = 16'($urandom_range(0, 511));
		c.black_level = 7'($urandom());
		c.center_level = 7'($urandom());
		c.trigger_count = 31'($urandom());
		return c;
	endfunction

	// mostly close to the target so the duties do not always saturate
	function automatic logic [6:0] pick_refl();
		logic [6:0] aim;
		int         v;
		aim = ramping ? trk_target : regs.center_level;
		if ($urandom_range(0, 3) == 0)
			return 7'($urandom());
		v = int'(aim) + int'($urandom_range(0, 24)) - 12;
		if (v < 0)
			v = 0;
		else if (v > 127)
			v = 127;
		return 7'(v);
	endfunction

	function automatic logic signed [31:0] enc_below();
		logic [31:0] r;
		r = $urandom();
		if ($urandom_range(0, 7) == 0 && regs.trigger_count != '0)
			return {1'b0, regs.trigger_count} - 32'd1;
		if (!r[31] && r[30:0] >= regs.trigger_count)
			r[31] = 1'b1;
		return r;
	endfunction

	task automatic send_tick(input logic [6:0] refl, input logic signed [31:0] enc,
			input logic typed, input duty_t typed_want);
		int    gap;
		duty_t calc;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		reflection <= refl;
		encoder_count <= enc;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		calc = follow_tick(refl, enc);
		due_duties.push_back(typed ? typed_want : calc);
	endtask

	// waits for the block to drain, then rewrites every register
	task automatic configure(input cfg_t next);
		logic [31:0] val;
		logic [2:0]  idx;
		in_valid <= 1'b0;
		while (due_duties.size() != 0) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			idx = 3'(i);
			case (idx)
				REG_PROP:   val = {16'd0, next.prop_gain_q8};
				REG_INTEG:  val = {16'd0, next.integ_gain_q8};
				REG_DERIV:  val = {16'd0, next.deriv_gain_per_dt_q8};
				REG_HALF:   val = {16'd0, next.half_tick_q16};
				REG_BOOST:  val = {16'd0, next.boost_gain_q8};
				REG_BLACK:  val = {25'd0, next.black_level};
				REG_CENTER: val = {25'd0, next.center_level};
				REG_TRIG:   val = {1'b0, next.trigger_count};
				default:    val = '0;
			endcase
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= val;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		regs = next;
	endtask

	initial begin : rx_side
		int    gap;
		duty_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			if (rx_hold_due) begin
				rx_hold_due = 1'b0;
				gap = RX_HOLD;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (due_duties.size() == 0) begin
				$error("output beat with no tick pending");
				n_fail++;
			end else begin
				want = due_duties.pop_front();
				if (left_duty !== want.left) begin
					$error("left_duty: expected %0d, got %0d", want.left, left_duty);
					n_fail++;
				end
				if (right_duty !== want.right) begin
					$error("right_duty: expected %0d, got %0d", want.right, right_duty);
					n_fail++;
				end
				if (target_level !== want.level) begin
					$error("target_level: expected %0d, got %0d", want.level, target_level);
					n_fail++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("line_follow_pid_edge_switch_top: mismatch");
		$finish;
	end

	initial begin : stimulus
		cfg_t       next;
		logic [6:0] held;
		logic       down_done, up_done;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		reflection <= '0;
		encoder_count <= '0;

		regs = '{prop_gain_q8: 16'd256, integ_gain_q8: 16'd0, deriv_gain_per_dt_q8: 16'd0,
			half_tick_q16: 16'd131, boost_gain_q8: 16'd44, black_level: 7'd0,
			center_level: 7'd50, trigger_count: 31'd720};
		trk_target = '0;
		last_err = '0;
		integ_acc = '0;
		ramp_ticks = '0;
		on_right = 1'b0;
		rising = 1'b0;
		ramping = 1'b0;
		latched = 1'b0;
		boosted = 1'b0;
		base_lvl = BASE_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIR_TABLE[k])
			send_tick(DIR_TABLE[k].refl, DIR_TABLE[k].enc, DIR_TABLE[k].typed, DIR_TABLE[k].want);

		// normal mode, left edge, trigger never reached
		for (int ph = 0; ph < PHASES; ph++) begin
			next = random_cfg();
			if (ph == 0)
				next = '1;
			else if (ph == 1)
				next = '0;
			configure(next);
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			if (ph == 2) begin
				// receiver stalls long while beats keep coming
				tx_gap_max = 0;
				rx_hold_due = 1'b1;
			end
			repeat (PHASE_TICKS) send_tick(pick_refl(), enc_below(), 1'b0, '0);
		end

		// the one and only ramp: down to black, edge flip, back up to centre
		next = random_cfg();
		next.center_level = 7'($urandom_range(14, 24));
		next.black_level = 7'($urandom_range(2, 5));
		next.trigger_count = 31'($urandom_range(1000, 1 << 20));
		configure(next);
		tx_gap_max = 18;
		rx_gap_max = 18;
		repeat (2) send_tick(pick_refl(), {1'b0, regs.trigger_count} - 32'd1, 1'b0, '0);
		send_tick(pick_refl(), {1'b0, regs.trigger_count}, 1'b0, '0);
		send_tick(pick_refl(), 32'sh7fff_ffff, 1'b0, '0);
		down_done = 1'b0;
		up_done = 1'b0;
		while (ramping) begin
			if (!down_done && !rising && trk_target == regs.black_level + 7'd3) begin
				// black above the target holds the ramp
				down_done = 1'b1;
				next = regs;
				held = regs.black_level;
				next.black_level = trk_target + 7'd2;
				next.prop_gain_q8 = 16'($urandom_range(0, 600));
				configure(next);
				repeat (6) send_tick(pick_refl(), $urandom(), 1'b0, '0);
				next.black_level = held;
				configure(next);
			end
			if (!up_done && rising && trk_target == regs.center_level - 7'd3) begin
				// centre at or below the target holds the ramp, it must not end
				up_done = 1'b1;
				next = regs;
				held = regs.center_level;
				next.center_level = trk_target - 7'($urandom_range(0, 1));
				next.deriv_gain_per_dt_q8 = 16'($urandom_range(0, 600));
				configure(next);
				repeat (6) send_tick(pick_refl(), $urandom(), 1'b0, '0);
				next.center_level = held;
				configure(next);
			end
			send_tick(pick_refl(), $urandom(), 1'b0, '0);
		end

		// normal mode again, now on the right edge for good
		for (int ph = 0; ph < PHASES; ph++) begin
			configure(random_cfg());
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
			repeat (PHASE_TICKS) send_tick(pick_refl(), $urandom(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (due_duties.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("line_follow_pid_edge_switch_top: match");
		else
			$display("line_follow_pid_edge_switch_top: mismatch");
		$finish;
	end

endmodule
